// ===== design/clt_pkg.sv =====
package clt_pkg;

    // Command codes carried in the mode field
    localparam logic [3:0] MODE_INS_FRONT = 4'd0;
    localparam logic [3:0] MODE_INS_REAR  = 4'd1;
    localparam logic [3:0] MODE_RM_FRONT  = 4'd2;
    localparam logic [3:0] MODE_RM_REAR   = 4'd3;
    localparam logic [3:0] MODE_READ_CUR  = 4'd4;
    localparam logic [3:0] MODE_RM_CUR    = 4'd5;
    localparam logic [3:0] MODE_FIND_NUM  = 4'd6;
    localparam logic [3:0] MODE_FIND_NAME = 4'd7;
    localparam logic [3:0] MODE_READ_ALL  = 4'd8;
    localparam logic [3:0] MODE_CLEAR     = 4'd9;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic [3:0]  mode;
        logic [31:0] number;
        logic [63:0] name_low;
        logic [7:0]  name_high;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_number;
        logic [63:0] out_name_low;
        logic [7:0]  out_name_high;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INSERT,
        S_WALK,
        S_WALK_WAIT,
        S_REMOVE,
        S_EMIT_REC,
        S_EMIT_NONE,
        S_OUT_WAIT
    } ctl_state_t;

    // Walk purpose
    typedef enum logic [1:0] {
        W_PRED,
        W_FIND,
        W_ALL
    } walk_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch_cmd;
        logic       do_insert;
        logic       walk_start;
        logic       walk_step;
        logic       do_remove;
        logic       do_clear;
        logic       set_cur_hit;
        logic       rd_issue;
        logic       emit;
        logic       emit_rec;
        logic [1:0] emit_status;
        logic       emit_last;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [3:0] mode;
        logic       empty;
        logic       full;
        logic       cur_valid;
        logic       walk_done;
        logic       walk_hit;
        logic       all_last;
        logic       out_busy;
        logic       victim_head;
        logic       victim_tail;
        logic       one_left;
    } dp_sts_t;

endpackage

// ===== design/clt_if.sv =====
interface clt_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/clt_datapath.sv =====
module clt_datapath #(
    parameter int POOL_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  clt_pkg::cmd_t    cmd_in,
    input  clt_pkg::dp_cmd_t dp_cmd,
    output clt_pkg::dp_sts_t dp_sts,
    output clt_pkg::rsp_t    rsp_data,
    output logic             rsp_valid,
    input  logic             rsp_ready
);
    import clt_pkg::*;

    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    // Node pool
    logic [31:0] num_mem  [POOL_DEPTH];
    logic [63:0] nlo_mem  [POOL_DEPTH];
    logic [7:0]  nhi_mem  [POOL_DEPTH];
    logic [IW-1:0] link_mem [POOL_DEPTH];

    logic [POOL_DEPTH-1:0] free_reg, free_next;
    logic [IW-1:0] head_reg, head_next, tail_reg, tail_next, cur_reg, cur_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [CW-1:0] count_reg, count_next;
    cmd_t          cmd_reg;

    // Walker
    logic [IW-1:0] walk_ptr_reg, prev_ptr_reg, victim_reg;
    logic [CW-1:0] walk_n_reg;
    logic [RW-1:0] all_n_reg;
    walk_kind_t    walk_kind_reg;
    logic          walk_done_reg, walk_hit_reg;

    // Registered read port
    logic [31:0] rd_num;
    logic [63:0] rd_nlo;
    logic [7:0]  rd_nhi;
    logic [IW-1:0] rd_link;

    rsp_t rsp_reg;
    logic rsp_valid_reg;

    // Free slot search
    logic [IW-1:0] alloc_idx;
    logic          alloc_ok;
    always_comb
    begin
        alloc_idx = '0;
        alloc_ok  = 1'b0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                alloc_idx = IW'(i);
                alloc_ok  = 1'b1;
            end
        end
    end

    // Name compare as a nine byte string
    function automatic logic name_eq(input logic [71:0] a, input logic [71:0] b);
        logic r, stop;
        r = 1'b1;
        stop = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            if (!stop)
            begin
                if (a[8*k +: 8] != b[8*k +: 8])
                begin
                    r = 1'b0;
                    stop = 1'b1;
                end
                else if (a[8*k +: 8] == 8'd0)
                begin
                    stop = 1'b1;
                end
            end
        end
        return r;
    endfunction

    logic hit_now;
    assign hit_now = (cmd_reg.mode == MODE_FIND_NUM) ? (rd_num == cmd_reg.number)
                   : name_eq({rd_nhi, rd_nlo}, {cmd_reg.name_high, cmd_reg.name_low});

    // Memory read of the walk pointer, and writes on insert
    logic [IW-1:0] rd_addr;
    assign rd_addr = walk_ptr_reg;

    always_ff @(posedge clk)
    begin
        rd_num  <= num_mem[rd_addr];
        rd_nlo  <= nlo_mem[rd_addr];
        rd_nhi  <= nhi_mem[rd_addr];
        rd_link <= link_mem[rd_addr];
        if (dp_cmd.do_insert && alloc_ok)
        begin
            num_mem[alloc_idx] <= cmd_reg.number;
            nlo_mem[alloc_idx] <= cmd_reg.name_low;
            nhi_mem[alloc_idx] <= cmd_reg.name_high;
        end
    end

    // Link writes: one per cycle
    logic          lw_en;
    logic [IW-1:0] lw_addr, lw_data;
    logic          lw2_en;
    logic [IW-1:0] lw2_addr, lw2_data;
    always_ff @(posedge clk)
    begin
        if (lw_en)
            link_mem[lw_addr] <= lw_data;
        else if (lw2_en)
            link_mem[lw2_addr] <= lw2_data;
    end

    // Pending second link write (insert into a non-empty list needs two)
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_addr_reg, pend_addr_next, pend_data_reg, pend_data_next;
    logic [IW-1:0] vlink_reg;

    assign lw2_en   = pend_reg;
    assign lw2_addr = pend_addr_reg;
    assign lw2_data = pend_data_reg;

    // List state update
    always_comb
    begin
        free_next      = free_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        count_next     = count_reg;
        lw_en          = 1'b0;
        lw_addr        = '0;
        lw_data        = '0;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_data_next = pend_data_reg;

        if (dp_cmd.do_clear)
        begin
            free_next      = '1;
            head_next      = '0;
            tail_next      = '0;
            cur_next       = '0;
            cur_valid_next = 1'b0;
            count_next     = '0;
        end
        else if (dp_cmd.do_insert && alloc_ok)
        begin
            free_next[alloc_idx] = 1'b0;
            cur_next       = alloc_idx;
            cur_valid_next = 1'b1;
            count_next     = count_reg + 1'b1;
            lw_en          = 1'b1;
            lw_addr        = alloc_idx;
            if (count_reg == '0)
            begin
                head_next = alloc_idx;
                tail_next = alloc_idx;
                lw_data   = alloc_idx;
            end
            else
            begin
                lw_data        = head_reg;
                pend_next      = 1'b1;
                pend_addr_next = tail_reg;
                pend_data_next = alloc_idx;
                if (cmd_reg.mode == MODE_INS_FRONT)
                    head_next = alloc_idx;
                else
                    tail_next = alloc_idx;
            end
        end
        else if (dp_cmd.do_remove)
        begin
            free_next[victim_reg] = 1'b1;
            count_next = count_reg - 1'b1;
            if (count_reg <= CW'(1))
            begin
                head_next      = '0;
                tail_next      = '0;
                cur_next       = '0;
                cur_valid_next = 1'b0;
                count_next     = '0;
            end
            else if (victim_reg == head_reg)
            begin
                head_next      = vlink_reg;
                cur_next       = vlink_reg;
                cur_valid_next = 1'b1;
                lw_en          = 1'b1;
                lw_addr        = tail_reg;
                lw_data        = vlink_reg;
            end
            else
            begin
                // prev_ptr_reg holds the predecessor found by the walk
                cur_next       = prev_ptr_reg;
                cur_valid_next = 1'b1;
                lw_en          = 1'b1;
                lw_addr        = prev_ptr_reg;
                lw_data        = vlink_reg;
                if (victim_reg == tail_reg)
                    tail_next = prev_ptr_reg;
            end
        end
        else if (dp_cmd.set_cur_hit)
        begin
            cur_next       = walk_ptr_reg;
            cur_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= '1;
            head_reg      <= '0;
            tail_reg      <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            free_reg      <= free_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        if (dp_cmd.latch_cmd)
            cmd_reg <= cmd_in;
    end

    // Link walker: pointer advances from the registered link read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_done_reg <= 1'b0;
            walk_hit_reg  <= 1'b0;
            walk_n_reg    <= '0;
            all_n_reg     <= '0;
            walk_kind_reg <= W_PRED;
            walk_ptr_reg  <= '0;
            prev_ptr_reg  <= '0;
            victim_reg    <= '0;
            vlink_reg     <= '0;
        end
        else if (dp_cmd.walk_start)
        begin
            // Single record reads start at the current entry, walks at the head
            case (cmd_reg.mode)
                MODE_INS_FRONT, MODE_INS_REAR, MODE_READ_CUR: walk_ptr_reg <= cur_reg;
                default:                                      walk_ptr_reg <= head_reg;
            endcase
            prev_ptr_reg <= tail_reg;
            walk_n_reg   <= '0;
            all_n_reg    <= '0;
            walk_hit_reg <= 1'b0;
            walk_done_reg <= 1'b0;
            case (cmd_reg.mode)
                MODE_FIND_NUM, MODE_FIND_NAME: walk_kind_reg <= W_FIND;
                MODE_READ_ALL:                 walk_kind_reg <= W_ALL;
                default:                       walk_kind_reg <= W_PRED;
            endcase
            case (cmd_reg.mode)
                MODE_RM_FRONT: victim_reg <= head_reg;
                MODE_RM_REAR:  victim_reg <= tail_reg;
                default:       victim_reg <= cur_reg;
            endcase
        end
        else if (dp_cmd.walk_step)
        begin
            // rd_* now holds the node at walk_ptr_reg
            case (walk_kind_reg)
                W_FIND:
                begin
                    if (hit_now)
                    begin
                        walk_hit_reg  <= 1'b1;
                        walk_done_reg <= 1'b1;
                    end
                    else if (walk_n_reg + 1'b1 >= count_reg)
                    begin
                        walk_done_reg <= 1'b1;
                    end
                    else
                    begin
                        walk_ptr_reg <= rd_link;
                        walk_n_reg   <= walk_n_reg + 1'b1;
                    end
                end
                W_PRED:
                begin
                    if (walk_ptr_reg == victim_reg)
                    begin
                        vlink_reg     <= rd_link;
                        walk_done_reg <= 1'b1;
                    end
                    else
                    begin
                        prev_ptr_reg <= walk_ptr_reg;
                        walk_ptr_reg <= rd_link;
                    end
                end
                default:
                begin
                    walk_ptr_reg <= rd_link;
                    all_n_reg    <= all_n_reg + 1'b1;
                end
            endcase
        end
    end

    logic all_last;
    assign all_last = (CW'(all_n_reg) + 1'b1 >= count_reg) ||
                      (all_n_reg == RW'(MAX_RESULTS - 1));

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (dp_cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.emit)
        begin
            rsp_reg.status <= dp_cmd.emit_status;
            rsp_reg.last   <= dp_cmd.emit_last;
            if (dp_cmd.emit_rec)
            begin
                rsp_reg.out_number    <= rd_num;
                rsp_reg.out_name_low  <= rd_nlo;
                rsp_reg.out_name_high <= rd_nhi;
            end
            else
            begin
                rsp_reg.out_number    <= '0;
                rsp_reg.out_name_low  <= '0;
                rsp_reg.out_name_high <= '0;
            end
        end
    end

    // rd_issue is used by the controller only as a wait slot for the read
    logic unused_rd;
    assign unused_rd = dp_cmd.rd_issue;

    assign rsp_data  = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        dp_sts.mode        = cmd_reg.mode;
        dp_sts.empty       = (count_reg == '0);
        dp_sts.full        = !alloc_ok;
        dp_sts.cur_valid   = cur_valid_reg;
        dp_sts.walk_done   = walk_done_reg;
        dp_sts.walk_hit    = walk_hit_reg;
        dp_sts.all_last    = all_last || unused_rd & 1'b0;
        dp_sts.out_busy    = rsp_valid_reg && !rsp_ready;
        dp_sts.victim_head = (victim_reg == head_reg);
        dp_sts.victim_tail = (victim_reg == tail_reg);
        dp_sts.one_left    = (count_reg == CW'(1));
    end

endmodule

// ===== design/clt_ctrl.sv =====
module clt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  clt_pkg::dp_sts_t dp_sts,
    output clt_pkg::dp_cmd_t dp_cmd
);
    import clt_pkg::*;

    ctl_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
                if (dp_sts.out_busy)
                    state_next = S_DECODE;
                else
                    case (dp_sts.mode)
                        MODE_INS_FRONT, MODE_INS_REAR:
                            state_next = dp_sts.full ? S_EMIT_NONE : S_INSERT;
                        MODE_RM_FRONT, MODE_RM_REAR, MODE_RM_CUR, MODE_READ_CUR:
                            if (dp_sts.empty ||
                                ((dp_sts.mode == MODE_RM_CUR || dp_sts.mode == MODE_READ_CUR)
                                 && !dp_sts.cur_valid))
                                state_next = S_EMIT_NONE;
                            else
                                state_next = S_WALK_WAIT;
                        MODE_FIND_NUM, MODE_FIND_NAME, MODE_READ_ALL:
                            state_next = dp_sts.empty ? S_EMIT_NONE : S_WALK_WAIT;
                        default:
                            state_next = S_EMIT_NONE;
                    endcase
            S_INSERT:
                state_next = S_WALK_WAIT;
            S_WALK_WAIT:
                state_next = S_WALK;
            S_WALK:
                case (dp_sts.mode)
                    MODE_READ_ALL:
                        if (!dp_sts.out_busy)
                            state_next = dp_sts.all_last ? S_OUT_WAIT : S_WALK_WAIT;
                    MODE_INS_FRONT, MODE_INS_REAR, MODE_READ_CUR:
                        if (!dp_sts.out_busy)
                            state_next = S_OUT_WAIT;
                    default:
                        // each step needs a fresh read of the next node
                        state_next = dp_sts.walk_done ? S_EMIT_REC : S_WALK_WAIT;
                endcase
            S_EMIT_REC:
                if (!dp_sts.out_busy)
                    state_next = (dp_sts.mode == MODE_RM_FRONT || dp_sts.mode == MODE_RM_REAR
                                  || dp_sts.mode == MODE_RM_CUR) ? S_REMOVE : S_OUT_WAIT;
            S_REMOVE:
                state_next = S_OUT_WAIT;
            S_EMIT_NONE:
                state_next = S_OUT_WAIT;
            S_OUT_WAIT:
                if (!dp_sts.out_busy)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Outputs
    always_comb
    begin
        dp_cmd = '0;
        in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
                dp_cmd.latch_cmd = in_valid;
            S_DECODE:
                if (!dp_sts.out_busy)
                    case (dp_sts.mode)
                        MODE_INS_FRONT, MODE_INS_REAR:
                        begin
                            dp_cmd.do_insert = !dp_sts.full;
                        end
                        MODE_RM_FRONT, MODE_RM_REAR, MODE_RM_CUR, MODE_READ_CUR,
                        MODE_FIND_NUM, MODE_FIND_NAME, MODE_READ_ALL:
                            dp_cmd.walk_start = 1'b1;
                        MODE_CLEAR:
                            dp_cmd.do_clear = 1'b1;
                        default:
                            dp_cmd.walk_start = 1'b0;
                    endcase
            S_INSERT:
                dp_cmd.walk_start = 1'b1;
            S_WALK_WAIT:
                dp_cmd.rd_issue = 1'b1;
            S_WALK:
                case (dp_sts.mode)
                    MODE_READ_ALL:
                        if (!dp_sts.out_busy)
                        begin
                            dp_cmd.emit        = 1'b1;
                            dp_cmd.emit_rec    = 1'b1;
                            dp_cmd.emit_status = ST_OK;
                            dp_cmd.emit_last   = dp_sts.all_last;
                            dp_cmd.walk_step   = 1'b1;
                        end
                    MODE_INS_FRONT, MODE_INS_REAR, MODE_READ_CUR:
                        if (!dp_sts.out_busy)
                        begin
                            dp_cmd.emit        = 1'b1;
                            dp_cmd.emit_rec    = 1'b1;
                            dp_cmd.emit_status = ST_OK;
                            dp_cmd.emit_last   = 1'b1;
                        end
                    default:
                        if (!dp_sts.walk_done)
                            dp_cmd.walk_step = 1'b1;
                endcase
            S_EMIT_REC:
                if (!dp_sts.out_busy)
                begin
                    dp_cmd.emit      = 1'b1;
                    dp_cmd.emit_last = 1'b1;
                    if ((dp_sts.mode == MODE_FIND_NUM || dp_sts.mode == MODE_FIND_NAME)
                        && !dp_sts.walk_hit)
                    begin
                        dp_cmd.emit_status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        dp_cmd.emit_rec    = 1'b1;
                        dp_cmd.emit_status = ST_OK;
                        dp_cmd.set_cur_hit = (dp_sts.mode == MODE_FIND_NUM ||
                                              dp_sts.mode == MODE_FIND_NAME);
                    end
                end
            S_REMOVE:
                dp_cmd.do_remove = 1'b1;
            S_EMIT_NONE:
            begin
                dp_cmd.emit      = 1'b1;
                dp_cmd.emit_last = 1'b1;
                case (dp_sts.mode)
                    MODE_INS_FRONT, MODE_INS_REAR: dp_cmd.emit_status = ST_FULL;
                    MODE_RM_FRONT, MODE_RM_REAR, MODE_RM_CUR, MODE_READ_CUR,
                    MODE_READ_ALL:                 dp_cmd.emit_status = ST_EMPTY;
                    MODE_FIND_NUM, MODE_FIND_NAME: dp_cmd.emit_status = ST_NOT_FOUND;
                    default:                       dp_cmd.emit_status = ST_OK;
                endcase
            end
            default:
                dp_cmd.emit = 1'b0;
        endcase
    end

endmodule

// ===== design/circular_list_table_engine.sv =====
// Insert and read current read only the entry at the current pointer; remove,
// search and read all walk the links from the head, with a registered link read
// for each node. One command is in work at a time.
// Read all gives one result per node, up to MAX_RESULTS, stalling on output.
// Reset: asynchronous active low; pool all free, list empty, no current entry.
module circular_list_table_engine #(
    parameter int POOL_DEPTH = 32
) (
    input logic clk,
    input logic rst_n,
    clt_if.sink   cmd,
    clt_if.source rsp
);
    import clt_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    clt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .dp_sts   (dp_sts),
        .dp_cmd   (dp_cmd)
    );

    clt_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd.payload),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts),
        .rsp_data  (rsp.payload),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready)
    );

endmodule
